/* rtl/rgr_pkg.sv */
// Shared types and constants of the glyph rasterizer.
`timescale 1ns / 1ps
package rgr_pkg;

   localparam int NUM_INKS      = 7;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int COLOR_W       = 16;
   localparam int BLEND_BIT_POS = 15;

   localparam logic [7:0]         CODE_BLANK    = 8'd0;
   localparam logic [7:0]         CODE_SKIP_MIN = 8'd8;
   localparam logic [7:0]         CODE_END      = 8'd255;
   localparam logic [7:0]         SKIP_BIAS     = 8'd6;
   localparam logic [COLOR_W-1:0] NOT_DRAWN     = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BLEND_MASK    = COLOR_W'(1) << BLEND_BIT_POS;

   typedef logic [NUM_INKS-1:0][COLOR_W-1:0] palette_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEIGHT,
      PH_CODES
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SKIP,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } step_ctrl_type;

   typedef struct packed {
      logic               pixel_write;
      logic [7:0]         column;
      logic [7:0]         row;
      logic [COLOR_W-1:0] pixel_color;
      logic               blend;
      logic               glyph_done;
   } result_type;

endpackage

/* rtl/rle_glyph_rasterizer.sv */
// Top level: byte sequencer, palette lookup and result register.
//
// Usage: glyph record bytes enter on the req_ channel, one byte per item;
// req_record_start marks the width byte, the next byte is the height.
// Each code byte yields at most one item on the rsp_ channel: a pixel
// write, a glyph end, or both. Ink colors are written through the csr_
// port while the block is idle.
// Timing: a skip code n (8..254) makes the position walker advance n-6
// positions, one position per cycle. A byte that yields a result is first
// held in the pending register and then moves into the output register,
// from which it appears on rsp_.
// req_stall is high while a skip run is walked or a result waits for the
// output register; the next byte is taken once both are done.
// Reset: synchronous; clears the record phase, the walker and the output
// valid, and sets every ink color to 0xFFFF (not drawn).
// Stall: while rsp_stall is high the result holds in place; the next
// result waits inside with req_stall high until the output register frees.
`timescale 1ns / 1ps
module rle_glyph_rasterizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_record_start,
   input  logic [7:0]                      req_glyph_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_pixel_write,
   output logic [7:0]                      rsp_column,
   output logic [7:0]                      rsp_row,
   output logic [rgr_pkg::COLOR_W-1:0]     rsp_pixel_color,
   output logic                            rsp_blend_with_background,
   output logic                            rsp_glyph_done,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rgr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rgr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rgr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import rgr_pkg::*;

   palette_type   palette;
   step_ctrl_type step_ctrl;
   logic [7:0]    pos_column;
   logic [7:0]    pos_row;
   logic          pos_last;

   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]    width_ff, width_in;
   logic [7:0]    run_ff, run_in;
   result_type    pend_ff, pend_in;
   result_type    out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   logic               accept;
   logic               out_free;
   logic [8:0]         load_columns;
   logic [COLOR_W-1:0] ink;
   logic [2:0]         ink_index;

   rgr_palette u_palette (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .palette     (palette)
   );

   rgr_stepper u_stepper (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (step_ctrl),
      .load_height  (req_glyph_byte),
      .load_columns (load_columns),
      .column       (pos_column),
      .row          (pos_row),
      .last         (pos_last)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign load_columns = (width_ff == 8'd0) ? 9'd256 : {1'b0, width_ff};
   assign ink_index    = req_glyph_byte[2:0] - 3'd1;
   assign ink          = palette[ink_index];

   assign rsp_valid                 = out_valid_ff;
   assign rsp_pixel_write           = out_ff.pixel_write;
   assign rsp_column                = out_ff.column;
   assign rsp_row                   = out_ff.row;
   assign rsp_pixel_color           = out_ff.pixel_color;
   assign rsp_blend_with_background = out_ff.blend;
   assign rsp_glyph_done            = out_ff.glyph_done;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      width_in     = width_ff;
      run_in       = run_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      step_ctrl    = '0;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in = '0;
               if (req_record_start) begin
                  width_in = req_glyph_byte;
                  phase_in = PH_HEIGHT;
               end else if (phase_ff == PH_HEIGHT) begin
                  step_ctrl.load = 1'b1;
                  phase_in       = PH_CODES;
               end else if (phase_ff == PH_CODES) begin
                  if (req_glyph_byte == CODE_END) begin
                     pend_in.glyph_done = 1'b1;
                     phase_in           = PH_IDLE;
                     state_in           = ST_EMIT;
                  end else if (req_glyph_byte >= CODE_SKIP_MIN) begin
                     run_in   = req_glyph_byte - SKIP_BIAS;
                     state_in = ST_SKIP;
                  end else begin
                     if (req_glyph_byte != CODE_BLANK && ink != NOT_DRAWN) begin
                        pend_in.pixel_write = 1'b1;
                        pend_in.column      = pos_column;
                        pend_in.row         = pos_row;
                        pend_in.pixel_color = ink & ~BLEND_MASK;
                        pend_in.blend       = ink[BLEND_BIT_POS];
                     end
                     step_ctrl.step     = 1'b1;
                     pend_in.glyph_done = pos_last;
                     if (pos_last) begin
                        phase_in = PH_IDLE;
                     end
                     if (pend_in.pixel_write || pos_last) begin
                        state_in = ST_EMIT;
                     end
                  end
               end
            end
         end
         ST_SKIP: begin
            step_ctrl.step = 1'b1;
            run_in         = run_ff - 8'd1;
            if (pos_last) begin
               pend_in.glyph_done = 1'b1;
               phase_in           = PH_IDLE;
               state_in           = ST_EMIT;
            end else if (run_ff == 8'd1) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         width_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         width_ff     <= width_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff  <= run_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

endmodule

/* rtl/rgr_palette.sv */
// Ink color registers behind the APB-style configuration port.
`timescale 1ns / 1ps
module rgr_palette (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rgr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rgr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rgr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output rgr_pkg::palette_type            palette
);
   import rgr_pkg::*;

   palette_type ink_ff;
   palette_type ink_in;
   logic [2:0]  reg_index;
   logic        wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign palette    = ink_ff;

   always_comb begin
      ink_in = ink_ff;
      if (wr_en && (int'(reg_index) < NUM_INKS)) begin
         ink_in[reg_index] = csr_pwdata[COLOR_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (int'(reg_index) < NUM_INKS) begin
         csr_prdata = CSR_DATA_W'(ink_ff[reg_index]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_INKS; i++) begin
            ink_ff[i] <= NOT_DRAWN;
         end
      end else begin
         ink_ff <= ink_in;
      end
   end

endmodule

/* rtl/rgr_stepper.sv */
// Position walker: advances one pixel position per step, column-major.
`timescale 1ns / 1ps
module rgr_stepper (
   input  logic                  clock,
   input  logic                  reset,
   input  rgr_pkg::step_ctrl_type ctrl,
   input  logic [7:0]            load_height,
   input  logic [8:0]            load_columns,
   output logic [7:0]            column,
   output logic [7:0]            row,
   output logic                  last
);
   import rgr_pkg::*;

   logic [7:0] height_ff, height_in;
   logic [7:0] column_ff, column_in;
   logic [7:0] row_ff, row_in;
   logic [8:0] cols_left_ff, cols_left_in;
   logic [7:0] row_next;
   logic       col_end;

   assign row_next = row_ff + 8'd1;
   assign col_end  = (row_next == height_ff);
   assign last     = col_end && (cols_left_ff == 9'd1);
   assign column   = column_ff;
   assign row      = row_ff;

   always_comb begin
      height_in    = height_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      cols_left_in = cols_left_ff;
      if (ctrl.load) begin
         height_in    = load_height;
         column_in    = '0;
         row_in       = '0;
         cols_left_in = load_columns;
      end else if (ctrl.step) begin
         if (col_end) begin
            row_in       = '0;
            column_in    = column_ff + 8'd1;
            cols_left_in = cols_left_ff - 9'd1;
         end else begin
            row_in = row_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         cols_left_ff <= '0;
      end else begin
         height_ff    <= height_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         cols_left_ff <= cols_left_in;
      end
   end

endmodule
